>>> hw/rtl/ac3sc_pkg.sv
// ----------------------------------------------------------------------------
// AC-3 / E-AC-3 syncframe header check: shared package
// Types, header layout constants, error codes and the rate and length tables
// used by the capture front end and the decode back end.
// ----------------------------------------------------------------------------
package ac3sc_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int COUNT_LIMIT  = 8191;
    localparam int CNT_W        = 13;
    localparam logic [15:0] SYNC_WORD = 16'h0B77;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_WANT_ENH = 3'd0;
    localparam logic [2:0] REG_MIN_FB   = 3'd1;
    localparam logic [2:0] REG_MAX_LEG  = 3'd2;
    localparam logic [2:0] REG_MIN_ENH  = 3'd3;
    localparam logic [2:0] REG_MAX_ENH  = 3'd4;

    typedef enum logic [3:0] {
        E_OK        = 4'd0,
        E_TRUNC     = 4'd1,
        E_SYNC      = 4'd2,
        E_BSID      = 4'd3,
        E_CODEC     = 4'd4,
        E_RATE      = 4'd5,
        E_BITRATE   = 4'd6,
        E_SUBSTREAM = 4'd7,
        E_BLOCKS    = 4'd8,
        E_CHANNELS  = 4'd9,
        E_SIZE      = 4'd10
    } t_err;

    typedef struct packed {
        logic       want_enh;
        logic [6:0] min_fb;
        logic [3:0] max_leg;
        logic [4:0] min_enh;
        logic [4:0] max_enh;
    } t_cfg;

    // One finished frame as handed from the front end to the back end.
    typedef struct packed {
        logic [HEADER_BYTES-1:0][7:0] hdr;
        logic [CNT_W-1:0]             count;
    } t_frame;

    function automatic logic [9:0] kbps_tab(input logic [4:0] idx);
        logic [9:0] k;
        unique case (idx)
            5'd0:    k = 10'd32;
            5'd1:    k = 10'd40;
            5'd2:    k = 10'd48;
            5'd3:    k = 10'd56;
            5'd4:    k = 10'd64;
            5'd5:    k = 10'd80;
            5'd6:    k = 10'd96;
            5'd7:    k = 10'd112;
            5'd8:    k = 10'd128;
            5'd9:    k = 10'd160;
            5'd10:   k = 10'd192;
            5'd11:   k = 10'd224;
            5'd12:   k = 10'd256;
            5'd13:   k = 10'd320;
            5'd14:   k = 10'd384;
            5'd15:   k = 10'd448;
            5'd16:   k = 10'd512;
            5'd17:   k = 10'd576;
            5'd18:   k = 10'd640;
            default: k = 10'd0;
        endcase
        return k;
    endfunction

    // Words per frame at 44.1 kHz, rounded down: 320 * kbps / 147.
    function automatic logic [10:0] w44_tab(input logic [4:0] idx);
        logic [10:0] w;
        unique case (idx)
            5'd0:    w = 11'd69;
            5'd1:    w = 11'd87;
            5'd2:    w = 11'd104;
            5'd3:    w = 11'd121;
            5'd4:    w = 11'd139;
            5'd5:    w = 11'd174;
            5'd6:    w = 11'd208;
            5'd7:    w = 11'd243;
            5'd8:    w = 11'd278;
            5'd9:    w = 11'd348;
            5'd10:   w = 11'd417;
            5'd11:   w = 11'd487;
            5'd12:   w = 11'd557;
            5'd13:   w = 11'd696;
            5'd14:   w = 11'd835;
            5'd15:   w = 11'd975;
            5'd16:   w = 11'd1114;
            5'd17:   w = 11'd1253;
            5'd18:   w = 11'd1393;
            default: w = 11'd0;
        endcase
        return w;
    endfunction

    // Legacy frame length in bytes from fscod and frmsizecod.
    function automatic logic [CNT_W-1:0] legacy_bytes(input logic [1:0] fs,
                                                      input logic [5:0] fc);
        logic [9:0]  kbps;
        logic [12:0] w;
        kbps = kbps_tab(fc[5:1]);
        unique case (fs)
            2'd0:    w = {2'b0, kbps, 1'b0};
            2'd1:    w = {2'b0, w44_tab(fc[5:1])} + {12'b0, fc[0]};
            2'd2:    w = {3'b0, kbps} + {2'b0, kbps, 1'b0};
            default: w = 13'd0;
        endcase
        return {w[11:0], 1'b0};
    endfunction

    function automatic logic [15:0] rate_hz(input logic [1:0] fs);
        logic [15:0] r;
        unique case (fs)
            2'd0:    r = 16'd48000;
            2'd1:    r = 16'd44100;
            2'd2:    r = 16'd32000;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/ac3sc_front.sv
// ----------------------------------------------------------------------------
// AC-3 syncframe check: byte capture front end
// Keeps the first header bytes of the current frame and a saturating byte
// count, and hands the finished frame to the queue on the marked last word.
// ----------------------------------------------------------------------------
module ac3sc_front
    import ac3sc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_push,
    output t_frame     o_frame
);

    logic [HEADER_BYTES-1:0][7:0] r_hdr;
    logic [CNT_W-1:0]             r_count;
    logic [HEADER_BYTES-1:0][7:0] n_hdr;
    logic [CNT_W-1:0]             n_count;

    // The snapshot includes the word being accepted this cycle.
    always_comb begin
        n_hdr = r_hdr;
        if (r_count < CNT_W'(HEADER_BYTES)) begin
            n_hdr[r_count[HDR_IDX_W-1:0]] = i_data_byte;
        end
        n_count = r_count;
        if (r_count != CNT_W'(COUNT_LIMIT)) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    assign o_push        = i_accept && i_last_byte;
    assign o_frame.hdr   = n_hdr;
    assign o_frame.count = n_count;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hdr <= n_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= i_last_byte ? '0 : n_count;
        end
    end

    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_count == '0))
        else $error("byte count did not restart after the last word");

endmodule

>>> hw/rtl/ac3sc_queue.sv
// ----------------------------------------------------------------------------
// AC-3 syncframe check: frame queue
// Two-entry queue of finished frames between the front and back ends.
// ----------------------------------------------------------------------------
module ac3sc_queue
    import ac3sc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_nonempty,
    output t_frame o_head
);

    t_frame     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;

    assign o_full     = (r_level == 2'd2);
    assign o_nonempty = (r_level != 2'd0);
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_level <= r_level + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level <= 2'd2) && !(i_push && o_full) && !(i_pop && !o_nonempty))
        else $error("frame queue overflow or underflow");

endmodule

>>> hw/rtl/ac3sc_back.sv
// ----------------------------------------------------------------------------
// AC-3 syncframe check: header decode back end
// Decodes the queued frame header in priority order and holds the verdict
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module ac3sc_back
    import ac3sc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_nonempty,
    input  t_frame            i_frame,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [3:0]        o_error_code,
    output logic [15:0]       o_sample_rate_hz,
    output logic [1:0]        o_channel_count,
    output logic [CNT_W-1:0]  o_frame_length_bytes,
    output logic              o_is_enhanced
);

    logic             r_out_valid;
    t_err             r_err;
    logic [15:0]      r_rate;
    logic [1:0]       r_chans;
    logic [CNT_W-1:0] r_len;
    logic             r_enh;

    logic [CNT_W-1:0] cnt;
    logic [4:0]       bsid;
    logic             enh;
    logic             leg;
    logic [1:0]       fs;
    logic [2:0]       acmod;
    logic             lfeon;
    logic [CNT_W-1:0] len;
    logic             chans_bad;
    t_err             err;

    always_comb begin
        cnt  = i_frame.count;
        bsid = i_frame.hdr[5][7:3];
        enh  = (bsid >= i_cfg.min_enh) && (bsid <= i_cfg.max_enh);
        leg  = (bsid <= {1'b0, i_cfg.max_leg});
        fs   = i_frame.hdr[4][7:6];

        // The lfeon position in legacy frames moves with the mix level fields.
        if (enh) begin
            acmod = i_frame.hdr[4][3:1];
            lfeon = i_frame.hdr[4][0];
            len   = {i_frame.hdr[2][2:0], i_frame.hdr[3], 1'b0} + CNT_W'(2);
        end else begin
            acmod = i_frame.hdr[6][7:5];
            unique case (acmod)
                3'd0, 3'd1:             lfeon = i_frame.hdr[6][4];
                3'd2, 3'd3, 3'd4, 3'd6: lfeon = i_frame.hdr[6][2];
                default:                lfeon = i_frame.hdr[6][0];
            endcase
            len = legacy_bytes(fs, i_frame.hdr[4][5:0]);
        end
        chans_bad = ((acmod != 3'd1) && (acmod != 3'd2)) || lfeon;

        priority if (cnt < {6'b0, i_cfg.min_fb}) begin
            err = E_TRUNC;
        end else if (cnt < CNT_W'(2)) begin
            err = E_TRUNC;
        end else if ({i_frame.hdr[0], i_frame.hdr[1]} != SYNC_WORD) begin
            err = E_SYNC;
        end else if (cnt < CNT_W'(6)) begin
            err = E_TRUNC;
        end else if (!enh && !leg) begin
            err = E_BSID;
        end else if (enh != i_cfg.want_enh) begin
            err = E_CODEC;
        end else if (!enh && (fs == 2'd3)) begin
            err = E_RATE;
        end else if (!enh && (i_frame.hdr[4][5:1] >= 5'd19)) begin
            err = E_BITRATE;
        end else if (!enh && (cnt < CNT_W'(7))) begin
            err = E_TRUNC;
        end else if (enh && (i_frame.hdr[2][7:3] != 5'd0)) begin
            err = E_SUBSTREAM;
        end else if (enh && (fs == 2'd3)) begin
            err = E_RATE;
        end else if (enh && (i_frame.hdr[4][5:4] != 2'd3)) begin
            err = E_BLOCKS;
        end else if (chans_bad) begin
            err = E_CHANNELS;
        end else if ((len == '0) || (len != cnt)) begin
            err = E_SIZE;
        end else begin
            err = E_OK;
        end
    end

    assign o_pop = i_q_nonempty && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_err <= err;
            if (err == E_OK) begin
                r_rate  <= rate_hz(fs);
                r_chans <= (acmod == 3'd1) ? 2'd1 : 2'd2;
                r_len   <= len;
                r_enh   <= enh;
            end else begin
                r_rate  <= '0;
                r_chans <= '0;
                r_len   <= '0;
                r_enh   <= 1'b0;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_error_code         = r_err;
    assign o_sample_rate_hz     = r_rate;
    assign o_channel_count      = r_chans;
    assign o_frame_length_bytes = r_len;
    assign o_is_enhanced        = r_enh;

    a_err_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_err != E_OK)) |->
        ((r_rate == '0) && (r_chans == '0) && (r_len == '0) && !r_enh))
        else $error("failed frame reports nonzero fields");

    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_err == E_OK)) |->
        ((r_rate != '0) && (r_chans != '0) && (r_len != '0)))
        else $error("accepted frame reports an empty field");

endmodule

>>> hw/rtl/ac3_syncframe_header_check.sv
// ----------------------------------------------------------------------------
// AC-3 / E-AC-3 syncframe header check
// Path: the front end snapshot is queued when the marked last word is accepted,
//   and the back end decodes the queue head into the output register when that
//   register is free to take it.
// Throughput: one word per cycle while the frame queue is not full; a two-entry
//   frame queue and the output register decouple input and output stalls.
// Reset (synchronous, active low) empties the queue and output, zeroes the
//   byte count and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module ac3_syncframe_header_check
    import ac3sc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input word channel: one byte of the syncframe with its last-byte mark.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,

    // Result word channel: one verdict per frame.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_error_code,
    output logic [15:0] o_sample_rate_hz,
    output logic [1:0]  o_channel_count,
    output logic [12:0] o_frame_length_bytes,
    output logic        o_is_enhanced,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg   r_cfg;
    logic   in_accept;
    logic   push;
    t_frame push_frame;
    logic   q_full;
    logic   q_nonempty;
    t_frame q_head;
    logic   pop;
    logic   cfg_wr;
    logic [2:0] reg_idx;

    // The configuration registers. Writes must only be made while the block is
    // idle (the block does not enforce this), so the back end may read them directly while decoding.
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.want_enh <= 1'b0;
            r_cfg.min_fb   <= 7'd8;
            r_cfg.max_leg  <= 4'd8;
            r_cfg.min_enh  <= 5'd11;
            r_cfg.max_enh  <= 5'd16;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WANT_ENH: r_cfg.want_enh <= pwdata[0];
                REG_MIN_FB:   r_cfg.min_fb   <= pwdata[6:0];
                REG_MAX_LEG:  r_cfg.max_leg  <= pwdata[3:0];
                REG_MIN_ENH:  r_cfg.min_enh  <= pwdata[4:0];
                REG_MAX_ENH:  r_cfg.max_enh  <= pwdata[4:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WANT_ENH: prdata = {31'b0, r_cfg.want_enh};
            REG_MIN_FB:   prdata = {25'b0, r_cfg.min_fb};
            REG_MAX_LEG:  prdata = {28'b0, r_cfg.max_leg};
            REG_MIN_ENH:  prdata = {27'b0, r_cfg.min_enh};
            REG_MAX_ENH:  prdata = {27'b0, r_cfg.max_enh};
            default:      prdata = 32'b0;
        endcase
    end

    // The input stalls whenever the frame queue is full, not only when a finished
    // frame could not be queued; holding off on a full queue keeps the rule simple
    // and still lets words stream while a verdict waits at the output.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    ac3sc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_frame     (push_frame)
    );

    ac3sc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_frame    (push_frame),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    ac3sc_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_q_nonempty         (q_nonempty),
        .i_frame              (q_head),
        .o_pop                (pop),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_error_code         (o_error_code),
        .o_sample_rate_hz     (o_sample_rate_hz),
        .o_channel_count      (o_channel_count),
        .o_frame_length_bytes (o_frame_length_bytes),
        .o_is_enhanced        (o_is_enhanced)
    );

endmodule
